/* hdl/tsi_pkg.sv */
package tsi_pkg;

    localparam int FRAC_BITS = 8;

    localparam int SYM_W    = 8;
    localparam int COORD_W  = 24;
    localparam int STEP_W   = 16;
    localparam int STARTY_W = 23;
    localparam int RADIUS_W = 13;
    localparam int COUNT_W  = 32;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;

    localparam logic [SYM_W-1:0] SYM_MOVE  = 8'h46;
    localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h2D;

    localparam logic [MUL_W-1:0] HASH_MUL1 = 32'h9e3779b9;
    localparam logic [MUL_W-1:0] HASH_ADD1 = 32'h1D6100A1;
    localparam logic [MUL_W-1:0] HASH_MUL2 = 32'h7feb352d;
    localparam int HASH_SH1 = 16;
    localparam int HASH_SH2 = 15;
    localparam int HASH_BITS = 10;

    // Dot radius: base + floor(v * span / 1023), done as a reciprocal multiply.
    localparam longint RAD_BASE   = longint'(6) << FRAC_BITS;
    localparam longint RAD_SPAN   = longint'(14) << FRAC_BITS;
    localparam int     SCALE_W    = 14 + FRAC_BITS;
    localparam int     RECIP_SH   = SCALE_W + 10;
    localparam longint RECIP_MUL  = ((longint'(1) << RECIP_SH) + 1022) / 1023;

    localparam logic [COORD_W-1:0] STEP_RESET   = 24'd13645;
    localparam logic [STARTY_W-1:0] STARTY_RESET = 23'd204544;

    typedef enum logic [0:0] {
        REG_STEP_LENGTH = 1'b0,
        REG_START_Y     = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        HEAD_POS_X = 2'd0,
        HEAD_POS_Y = 2'd1,
        HEAD_NEG_X = 2'd2,
        HEAD_NEG_Y = 2'd3
    } t_heading;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MIX1,
        ST_MUL2,
        ST_MIX2,
        ST_MUL3,
        ST_SCALE,
        ST_MUL4,
        ST_DONE
    } t_state;

endpackage

/* hdl/turtle_symbol_interpreter.sv */
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+---------------------------------------
// input    | i_in_valid / o_in_stall         | i_symbol, i_restart
// output   | o_out_valid / i_out_stall       | o_kind, o_x_from, o_y_from, o_x_to,
//          |                                 | o_y_to, o_radius
// config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// Move and turn words use no multiply; a dot word steps through the multiply,
// mix, scale and done states as the single 32x32 multiplier runs the index
// hash and the radius scaling in four passes. Reset is synchronous, active low.
// A result stays in the output register until taken; a new word is taken only
// when the sequencer is idle and the output register is free or being emptied.
module turtle_symbol_interpreter
    import tsi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [SYM_W-1:0]           i_symbol,
    input  logic                       i_restart,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_kind,
    output logic signed [COORD_W-1:0]  o_x_from,
    output logic signed [COORD_W-1:0]  o_y_from,
    output logic signed [COORD_W-1:0]  o_x_to,
    output logic signed [COORD_W-1:0]  o_y_to,
    output logic [RADIUS_W-1:0]        o_radius,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_state                     r_state, n_state;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [STARTY_W-1:0]        r_start_y, n_start_y;
    logic signed [COORD_W-1:0]  r_pos_x, n_pos_x;
    logic signed [COORD_W-1:0]  r_pos_y, n_pos_y;
    logic [1:0]                 r_heading, n_heading;
    logic [COUNT_W-1:0]         r_count, n_count;
    logic [MUL_W-1:0]           r_opa, n_opa;
    logic [MUL_W-1:0]           r_opb, n_opb;
    logic [PROD_W-1:0]          r_prod, n_prod;

    logic                       r_out_valid, n_out_valid;
    logic                       r_kind, n_kind;
    logic signed [COORD_W-1:0]  r_x_from, n_x_from;
    logic signed [COORD_W-1:0]  r_y_from, n_y_from;
    logic signed [COORD_W-1:0]  r_x_to, n_x_to;
    logic signed [COORD_W-1:0]  r_y_to, n_y_to;
    logic [RADIUS_W-1:0]        r_radius, n_radius;

    logic                       out_free;
    logic                       in_accept;
    logic                       cfg_write;
    logic [PROD_W-1:0]          mul_result;
    logic signed [COORD_W-1:0]  base_x, base_y;
    logic [1:0]                 base_heading;
    logic [COUNT_W-1:0]         base_count;
    logic signed [COORD_W:0]    step_ext;
    logic signed [COORD_W:0]    sum_pos, sum_neg, sum_sel;
    logic signed [COORD_W-1:0]  sat_val;
    logic [MUL_W-1:0]           mix_val;
    logic [PROD_W-1:0]          scaled;
    logic [MUL_W-1:0]           radius_full;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    assign mul_result = PROD_W'(r_opa) * PROD_W'(r_opb);

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_STEP_LENGTH: prdata = {{(32-STEP_W){1'b0}}, r_step};
            REG_START_Y:     prdata = {{(32-STARTY_W){1'b0}}, r_start_y};
            default:         prdata = '0;
        endcase
    end

    assign base_x       = i_restart ? '0 : r_pos_x;
    assign base_y       = i_restart ? COORD_W'($signed({1'b0, r_start_y})) : r_pos_y;
    assign base_heading = i_restart ? HEAD_POS_X : r_heading;
    assign base_count   = i_restart ? '0 : r_count;

    assign step_ext = $signed({{(COORD_W+1-STEP_W){1'b0}}, r_step});

    always_comb begin
        if ((base_heading == HEAD_POS_X) || (base_heading == HEAD_NEG_X)) begin
            sum_pos = {base_x[COORD_W-1], base_x} + step_ext;
            sum_neg = {base_x[COORD_W-1], base_x} - step_ext;
        end else begin
            sum_pos = {base_y[COORD_W-1], base_y} + step_ext;
            sum_neg = {base_y[COORD_W-1], base_y} - step_ext;
        end
        if ((base_heading == HEAD_POS_X) || (base_heading == HEAD_POS_Y)) begin
            sum_sel = sum_pos;
        end else begin
            sum_sel = sum_neg;
        end
        if (sum_sel[COORD_W] != sum_sel[COORD_W-1]) begin
            sat_val = sum_sel[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                       : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_val = sum_sel[COORD_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_start_y   = r_start_y;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_count     = r_count;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_x_from    = r_x_from;
        n_y_from    = r_y_from;
        n_x_to      = r_x_to;
        n_y_to      = r_y_to;
        n_radius    = r_radius;
        mix_val     = '0;
        scaled      = '0;
        radius_full = '0;

        if (cfg_write) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_STEP_LENGTH: n_step    = pwdata[STEP_W-1:0];
                REG_START_Y:     n_start_y = pwdata[STARTY_W-1:0];
                default:         n_step    = r_step;
            endcase
        end

        unique case (r_state) inside
            ST_IDLE: begin
                if (in_accept) begin
                    n_pos_x   = base_x;
                    n_pos_y   = base_y;
                    n_heading = base_heading;
                    n_count   = base_count + COUNT_W'(1);
                    if (i_symbol == SYM_MOVE) begin
                        if ((base_heading == HEAD_POS_X) ||
                            (base_heading == HEAD_NEG_X)) begin
                            n_pos_x = sat_val;
                            n_x_to  = sat_val;
                            n_y_to  = base_y;
                        end else begin
                            n_pos_y = sat_val;
                            n_x_to  = base_x;
                            n_y_to  = sat_val;
                        end
                        n_out_valid = 1'b1;
                        n_kind      = 1'b0;
                        n_x_from    = base_x;
                        n_y_from    = base_y;
                        n_radius    = '0;
                    end else if (i_symbol == SYM_LEFT) begin
                        n_heading = base_heading + 2'd1;
                    end else if (i_symbol == SYM_RIGHT) begin
                        n_heading = base_heading - 2'd1;
                    end else begin
                        n_opa   = base_count;
                        n_opb   = HASH_MUL1;
                        n_state = ST_MUL1;
                    end
                end
            end
            ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4: begin
                n_prod = mul_result;
                unique case (r_state)
                    ST_MUL1: n_state = ST_MIX1;
                    ST_MUL2: n_state = ST_MIX2;
                    ST_MUL3: n_state = ST_SCALE;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_MIX1: begin
                mix_val = r_prod[MUL_W-1:0] + HASH_ADD1;
                mix_val = mix_val ^ (mix_val >> HASH_SH1);
                n_opa   = mix_val;
                n_opb   = HASH_MUL2;
                n_state = ST_MUL2;
            end
            ST_MIX2: begin
                mix_val = r_prod[MUL_W-1:0];
                mix_val = mix_val ^ (mix_val >> HASH_SH2);
                n_opa   = {{(MUL_W-HASH_BITS){1'b0}}, mix_val[HASH_BITS-1:0]};
                n_opb   = MUL_W'(RAD_SPAN);
                n_state = ST_MUL3;
            end
            ST_SCALE: begin
                n_opa   = r_prod[MUL_W-1:0];
                n_opb   = MUL_W'(RECIP_MUL);
                n_state = ST_MUL4;
            end
            ST_DONE: begin
                if (out_free) begin
                    scaled      = r_prod >> RECIP_SH;
                    radius_full = MUL_W'(RAD_BASE) + scaled[MUL_W-1:0];
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_x_from    = r_pos_x;
                    n_y_from    = r_pos_y;
                    n_x_to      = r_pos_x;
                    n_y_to      = r_pos_y;
                    n_radius    = radius_full[RADIUS_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_RESET[STEP_W-1:0];
            r_start_y   <= STARTY_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= HEAD_POS_X;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_start_y   <= n_start_y;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_prod   <= n_prod;
        r_kind   <= n_kind;
        r_x_from <= n_x_from;
        r_y_from <= n_y_from;
        r_x_to   <= n_x_to;
        r_y_to   <= n_y_to;
        r_radius <= n_radius;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_x_from    = r_x_from;
    assign o_y_from    = r_y_from;
    assign o_x_to      = r_x_to;
    assign o_y_to      = r_y_to;
    assign o_radius    = r_radius;

endmodule
